@@ src/ptnp_pkg.sv @@
// ----------------------------------------------------------------------------
// ptnp_pkg
// shared types and constants for the prime test and next prime block
// ----------------------------------------------------------------------------
package ptnp_pkg;

   // width of the next prime result
   localparam int NEXT_BITS = 32;

   // first trial divisor
   localparam int FIRST_DIVISOR = 2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_CHECK,
      ST_DIV,
      ST_TEST,
      ST_DONE
   } state_type;

endpackage

@@ src/prime_test_and_next_prime.sv @@
// ----------------------------------------------------------------------------
// prime_test_and_next_prime
// trial division primality test of one number plus search for the next prime
// ----------------------------------------------------------------------------
// Each transfer on req_ carries one number. The block reports whether the
// number is prime and the smallest prime strictly above it, in one transfer
// on rsp_. Numbers below 2 are not prime and their next prime is 2. All work
// runs through one shared bit-serial remainder unit under a small sequencer,
// so req_stall stays high from the accepted transfer until the result has
// been moved into the output register. Each tested candidate c uses trial
// divisors 2, then odd values 3, 5, 7, ... while d * d <= c, stopping early
// at the first one that divides c; each divisor runs a restoring division
// in ST_DIV between the ST_CHECK and ST_TEST sequencing states. An item
// costs the test of the number itself plus the tests of every candidate up
// to the next prime. A prime near 2^31 needs about 23,000 trial divisors.
// A finished result waits in the output register, so the next number is
// taken while it waits.
// ----------------------------------------------------------------------------
module prime_test_and_next_prime #(
   parameter int VALUE_BITS = 31
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [VALUE_BITS-1:0]           req_number,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_is_prime_flag,
   output logic [ptnp_pkg::NEXT_BITS-1:0]  rsp_next_prime_value
);
   import ptnp_pkg::*;

   // candidate width: one bit above the input holds the next prime
   localparam int CW  = VALUE_BITS + 1;
   // divisor width: covers sqrt of any candidate plus one step beyond
   localparam int DW  = (CW + 1) / 2 + 1;
   // width of the running divisor square
   localparam int SQW = 2 * DW;
   // bit counter for the bit-serial remainder
   localparam int BW  = $clog2(CW);
   // common width for resizing the candidate onto the result port
   localparam int XW  = (CW > NEXT_BITS) ? CW : NEXT_BITS;

   state_type state_ff, state_in;

   logic [CW-1:0]        cand_ff, cand_in;        // candidate under test
   logic                 testing_ff, testing_in;  // verdict belongs to the input itself
   logic                 flag_ff, flag_in;        // primality of the input
   logic [DW-1:0]        div_ff, div_in;          // current trial divisor
   logic [SQW-1:0]       sq_ff, sq_in;            // square of the trial divisor
   logic [DW-1:0]        rem_ff, rem_in;          // partial remainder
   logic [BW-1:0]        bit_ff, bit_in;          // dividend bit being shifted in

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_flag_ff, rsp_flag_in;
   logic [NEXT_BITS-1:0] rsp_next_ff, rsp_next_in;

   // remainder unit: one restoring step per cycle
   logic [DW:0]          trial;
   logic [DW:0]          diff;
   logic                 fits;
   logic [DW-1:0]        rem_step;

   // verdict on the current candidate
   logic                 verdict_vld;
   logic                 verdict_prime;
   logic                 req_xfer;
   logic                 out_free;
   logic [XW-1:0]        cand_wide;

   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cand_wide = XW'(cand_ff);

   assign trial    = {rem_ff, cand_ff[bit_ff]};
   assign diff     = trial - {1'b0, div_ff};
   assign fits     = (trial >= {1'b0, div_ff});
   assign rem_step = fits ? diff[DW-1:0] : trial[DW-1:0];

   // verdict detection
   always_comb begin
      verdict_vld   = 1'b0;
      verdict_prime = 1'b0;
      case (state_ff)
         ST_START: begin
            // zero and one are not prime
            if (cand_ff < CW'(FIRST_DIVISOR)) begin
               verdict_vld = 1'b1;
            end
         end
         ST_CHECK: begin
            // no divisor up to the square root
            if (sq_ff > SQW'(cand_ff)) begin
               verdict_vld   = 1'b1;
               verdict_prime = 1'b1;
            end
         end
         ST_TEST: begin
            // divisor found
            if (rem_ff == '0) begin
               verdict_vld = 1'b1;
            end
         end
         default: begin
            verdict_vld   = 1'b0;
            verdict_prime = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_START;
            end
         end
         ST_START, ST_CHECK, ST_TEST: begin
            if (verdict_vld) begin
               if (!testing_ff && verdict_prime) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_START;
               end
            end else if (state_ff == ST_CHECK) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_DIV: begin
            if (bit_ff == '0) begin
               state_in = ST_TEST;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and output control
   always_comb begin
      cand_in      = cand_ff;
      testing_in   = testing_ff;
      flag_in      = flag_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_flag_in  = rsp_flag_ff;
      rsp_next_in  = rsp_next_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cand_in    = CW'(req_number);
               testing_in = 1'b1;
            end
         end
         ST_START: begin
            div_in = DW'(FIRST_DIVISOR);
            sq_in  = SQW'(FIRST_DIVISOR * FIRST_DIVISOR);
         end
         ST_CHECK: begin
            rem_in = '0;
            bit_in = BW'(CW - 1);
         end
         ST_DIV: begin
            rem_in = rem_step;
            bit_in = bit_ff - 1'b1;
         end
         ST_TEST: begin
            // step from 2 to 3, then over odd divisors only
            if (div_ff == DW'(FIRST_DIVISOR)) begin
               div_in = div_ff + 1'b1;
               sq_in  = sq_ff + SQW'({div_ff, 1'b1});
            end else begin
               div_in = div_ff + DW'(2);
               sq_in  = sq_ff + SQW'({div_ff + 1'b1, 2'b00});
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = flag_ff;
               rsp_next_in  = cand_wide[NEXT_BITS-1:0];
            end
         end
         default: begin
            cand_in = cand_ff;
         end
      endcase

      // verdict handling: first the input, then the upward search
      if (verdict_vld) begin
         if (testing_ff) begin
            flag_in    = verdict_prime;
            testing_in = 1'b0;
            cand_in    = cand_ff + 1'b1;
         end else if (!verdict_prime) begin
            cand_in = cand_ff + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      testing_ff  <= testing_in;
      flag_ff     <= flag_in;
      div_ff      <= div_in;
      sq_ff       <= sq_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_next_ff <= rsp_next_in;
   end

   // busy from the accepted transfer until the result is handed over
   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_is_prime_flag    = rsp_flag_ff;
   assign rsp_next_prime_value = rsp_next_ff;

endmodule

@@ src/ptnp_checker.sv @@
// ----------------------------------------------------------------------------
// ptnp_checker
// port-level checks for the prime test and next prime block
// ----------------------------------------------------------------------------
module ptnp_checker #(
   parameter int VALUE_BITS = 31
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_is_prime_flag,
   input logic [ptnp_pkg::NEXT_BITS-1:0]  rsp_next_prime_value
);
   import ptnp_pkg::*;

   // after reset nothing is pending and the block takes input
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("ptnp: not idle after reset");

   // one item at a time: busy right after an accepted transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("ptnp: input taken while busy");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_is_prime_flag)
         && $stable(rsp_next_prime_value))
      else $error("ptnp: stalled result changed");

   // the next prime is at least the first prime
   a_next_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (VALUE_BITS >= NEXT_BITS)
         || (rsp_next_prime_value >= NEXT_BITS'(FIRST_DIVISOR)))
      else $error("ptnp: next prime below two");

endmodule

bind prime_test_and_next_prime ptnp_checker #(.VALUE_BITS(VALUE_BITS)) u_ptnp_checker (.*);
